// File: src/rocauc_pkg.sv
// Shared types and constants for the ROC area accumulator.
// Holds the port structs, the front-to-back queue entry and all derived widths.
// No dependencies.
`default_nettype none

package rocauc_pkg;

	// Field widths of the ports
	localparam int SCORE_W     = 32;
	localparam int LIMIT_W     = 10;
	localparam int AUC_W       = 23;
	localparam int COUNT_OUT_W = 20;

	// Internal counter and score widths
	localparam int COUNT_BITS  = 20;
	localparam int SCORE_BITS  = 32;
	localparam int SCORE_CMP_W = (SCORE_BITS < SCORE_W) ? SCORE_BITS : SCORE_W;

	localparam int SUM_W  = COUNT_BITS + 1;
	localparam int PROD_W = 2 * COUNT_BITS + 1;
	localparam int AREA_W = 2 * COUNT_BITS + 2;
	localparam int DIVA_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
	localparam int DEN_W  = DIVA_W + COUNT_BITS;

	// 100 percent in Q15 is 25 << 17, so the scaled area is (area * 25) << 17
	localparam int SCALE_W   = AREA_W + 5;
	localparam int QUOT_W    = 24;
	localparam int Q15_SHIFT = 17;
	localparam int HI_SHIFT  = QUOT_W - Q15_SHIFT;
	localparam int STEP_W    = $clog2(QUOT_W + 1);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX       = {COUNT_BITS{1'b1}};
	localparam logic [LIMIT_W-1:0]    NEG_LIMIT_RESET = LIMIT_W'(50);
	localparam logic [QUOT_W-1:0]     FULL_Q16        = QUOT_W'(6553600);

	// Configuration register indexes
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MODE      = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_NEG_LIMIT = 1'b1;

	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic                      is_positive;
		logic                      last;
	} in_item_t;

	typedef struct packed {
		logic [AUC_W-1:0]       auc_percent_q16;
		logic [COUNT_OUT_W-1:0] positives;
		logic [COUNT_OUT_W-1:0] negatives;
		logic                   overflowed;
	} result_t;

	typedef struct packed {
		logic               mode;
		logic [LIMIT_W-1:0] neg_limit;
	} cfg_t;

	// What the divider needs of a finished data set
	typedef struct packed {
		logic [COUNT_BITS-1:0] pos;
		logic [COUNT_BITS-1:0] neg;
		logic                  sat;
		logic [DIVA_W-1:0]     div_a;
	} set_info_t;

	// One classified item: the bin closed on entry, and on the last item the final bin
	typedef struct packed {
		logic [COUNT_BITS-1:0] dn_a;
		logic [SUM_W-1:0]      ps_a;
		logic [COUNT_BITS-1:0] dn_b;
		logic [SUM_W-1:0]      ps_b;
		logic                  last;
		set_info_t             info;
	} qentry_t;

	typedef struct packed {
		logic [AREA_W-1:0] total;
		set_info_t         info;
	} fin_t;

endpackage

`default_nettype wire

// File: src/roc_auc_accumulator.sv
// Top level of the ROC area accumulator: configuration registers, front end,
// queue, accumulator and divider. Depends on rocauc_pkg and all rocauc_* modules.
//
//   Channel   Handshake          Payload
//   input     push / full        item   (score, is_positive, last)
//   result    empty / pop        result (auc_percent_q16, positives, negatives, overflowed)
//   config    wr_en              wr_index, wr_data
//
// Items are taken one per cycle while full is low; the front end updates counts in
// the accept cycle. The last item of a set takes an extra pass through the multiplier,
// then the divider yields one quotient bit per cycle; the next set's items keep
// flowing into the queue meanwhile, and full rises when the queue backs up, behind
// the busy divider or behind the second pass that each last item takes.
// Reset clears all counts and sets neg_limit to 50.
`default_nettype none

module roc_auc_accumulator
	import rocauc_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	output logic                        full,
	input  wire in_item_t               item,
	output logic                        empty,
	input  wire logic                   pop,
	output result_t                     result,
	input  wire logic                   wr_en,
	input  wire logic [CFG_INDEX_W-1:0] wr_index,
	input  wire logic [LIMIT_W-1:0]     wr_data
);

	cfg_t    cfg_q;
	qentry_t front_entry, head_entry;
	logic    accept, q_full, q_empty, q_pop;
	fin_t    fin;
	logic    fin_valid, fin_ready;

	assign full   = q_full;
	assign accept = push && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode      <= 1'b0;
			cfg_q.neg_limit <= NEG_LIMIT_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_MODE:      cfg_q.mode      <= wr_data[0];
				CFG_NEG_LIMIT: cfg_q.neg_limit <= wr_data;
				default: ;
			endcase
		end
	end

	rocauc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.cfg    (cfg_q),
		.entry  (front_entry)
	);

	rocauc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.wr_entry (front_entry),
		.full     (q_full),
		.pop      (q_pop),
		.rd_entry (head_entry),
		.empty    (q_empty)
	);

	rocauc_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.entry     (head_entry),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.fin       (fin),
		.fin_valid (fin_valid),
		.fin_ready (fin_ready)
	);

	rocauc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.fin       (fin),
		.fin_valid (fin_valid),
		.fin_ready (fin_ready),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

`default_nettype wire

// File: src/rocauc_front.sv
// Front end: counts labels, detects score breaks and emits bin operands per item.
// Depends on rocauc_pkg.
`default_nettype none

module rocauc_front
	import rocauc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     accept,
	input  wire in_item_t item,
	input  wire cfg_t     cfg,
	output qentry_t       entry
);

	logic [COUNT_BITS-1:0]  neg_q, pos_q, nb_q, pb_q;
	logic [SCORE_CMP_W-1:0] prev_q;
	logic                   have_q;
	logic                   sat_q;

	logic [SCORE_CMP_W-1:0] score_c;
	logic                   changed, neg_open, close_a;
	logic [COUNT_BITS-1:0]  nb_a, pb_a, neg_n, pos_n;
	logic                   sat_n;

	always_comb begin
		score_c  = item.score[SCORE_CMP_W-1:0];
		changed  = !have_q || (score_c != prev_q);
		neg_open = !cfg.mode || (DIVA_W'(neg_q) < DIVA_W'(cfg.neg_limit));
		close_a  = changed && neg_open;

		nb_a = close_a ? neg_q : nb_q;
		pb_a = close_a ? pos_q : pb_q;

		pos_n = pos_q;
		neg_n = neg_q;
		sat_n = sat_q;
		if (item.is_positive) begin
			if (pos_q != COUNT_MAX) pos_n = pos_q + 1'b1;
			else sat_n = 1'b1;
		end else if (neg_open) begin
			if (neg_q != COUNT_MAX) neg_n = neg_q + 1'b1;
			else sat_n = 1'b1;
		end

		entry.dn_a       = close_a ? (neg_q - nb_q) : '0;
		entry.ps_a       = SUM_W'(pos_q) + SUM_W'(pb_q);
		entry.dn_b       = neg_n - nb_a;
		entry.ps_b       = SUM_W'(pos_n) + SUM_W'(pb_a);
		entry.last       = item.last;
		entry.info.pos   = pos_n;
		entry.info.neg   = neg_n;
		entry.info.sat   = sat_n;
		entry.info.div_a = cfg.mode ? DIVA_W'(cfg.neg_limit) : DIVA_W'(neg_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q  <= '0;
			pos_q  <= '0;
			nb_q   <= '0;
			pb_q   <= '0;
			prev_q <= '0;
			have_q <= 1'b0;
			sat_q  <= 1'b0;
		end else if (accept) begin
			if (item.last) begin
				// The data set is complete; start the next one from scratch.
				neg_q  <= '0;
				pos_q  <= '0;
				nb_q   <= '0;
				pb_q   <= '0;
				prev_q <= '0;
				have_q <= 1'b0;
				sat_q  <= 1'b0;
			end else begin
				neg_q <= neg_n;
				pos_q <= pos_n;
				nb_q  <= nb_a;
				pb_q  <= pb_a;
				sat_q <= sat_n;
				if (close_a) begin
					prev_q <= score_c;
					have_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: src/rocauc_queue.sv
// Short register queue between the front end and the accumulator.
// Depends on rocauc_pkg for the entry type.
`default_nettype none

module rocauc_queue
	import rocauc_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire qentry_t wr_entry,
	output logic         full,
	input  wire logic    pop,
	output qentry_t      rd_entry,
	output logic         empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	qentry_t           mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: src/rocauc_mac.sv
// Back-end accumulator: multiplies bin operands and sums the doubled area.
// Depends on rocauc_pkg; hands each finished data set to the divider.
`default_nettype none

module rocauc_mac
	import rocauc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire qentry_t entry,
	input  wire logic    q_empty,
	output logic         q_pop,
	output fin_t         fin,
	output logic         fin_valid,
	input  wire logic    fin_ready
);

	logic                  phase_q;
	logic                  valid_s1, fin_s1;
	logic [PROD_W-1:0]     prod_s1;
	set_info_t             info_s1;
	logic [AREA_W-1:0]     area_q;
	logic                  valid_s2;
	fin_t                  fin_s2;

	logic                  s2_free, s1_take, s1_load;
	logic [COUNT_BITS-1:0] dn;
	logic [SUM_W-1:0]      ps;
	logic [PROD_W-1:0]     prod;

	always_comb begin
		s2_free = !valid_s2 || fin_ready;
		s1_take = valid_s1 && (!fin_s1 || s2_free);
		s1_load = !q_empty && (!valid_s1 || s1_take);
		// A last item takes two passes: its entry bin first, then the final bin.
		q_pop   = s1_load && (phase_q || !entry.last);
		dn      = phase_q ? entry.dn_b : entry.dn_a;
		ps      = phase_q ? entry.ps_b : entry.ps_a;
		prod    = PROD_W'(dn) * PROD_W'(ps);
	end

	assign fin       = fin_s2;
	assign fin_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= 1'b0;
			valid_s1 <= 1'b0;
			fin_s1   <= 1'b0;
			area_q   <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_load) begin
				valid_s1 <= 1'b1;
				fin_s1   <= phase_q;
				phase_q  <= entry.last && !phase_q;
			end else if (s1_take) begin
				valid_s1 <= 1'b0;
			end

			if (s1_take && !fin_s1) begin
				area_q <= area_q + AREA_W'(prod_s1);
			end

			if (s1_take && fin_s1) begin
				area_q   <= '0;
				valid_s2 <= 1'b1;
			end else if (fin_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			prod_s1 <= prod;
			info_s1 <= entry.info;
		end
		if (s1_take && fin_s1) begin
			fin_s2.total <= area_q + AREA_W'(prod_s1);
			fin_s2.info  <= info_s1;
		end
	end

endmodule

`default_nettype wire

// File: src/rocauc_div.sv
// Scales the doubled area to percent and divides it by the set's divisor,
// one quotient bit per cycle, then holds the result item. Depends on rocauc_pkg.
`default_nettype none

module rocauc_div
	import rocauc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire fin_t fin,
	input  wire logic fin_valid,
	output logic      fin_ready,
	output result_t   result,
	output logic      empty,
	input  wire logic pop
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_ITER,
		ST_DONE
	} state_t;

	state_t               state_q;
	logic [SCALE_W-1:0]   scaled_q;
	logic [DEN_W-1:0]     den_q;
	set_info_t            info_q;
	logic [DEN_W-1:0]     rem_q;
	logic [QUOT_W-1:0]    low_q;
	logic [QUOT_W-1:0]    quo_q;
	logic [STEP_W-1:0]    step_q;
	result_t              out_q;
	logic                 out_valid_q;

	logic [SCALE_W-1:0]   scaled_in;
	logic [DEN_W-1:0]     scaled_hi;
	logic [DEN_W:0]       trial, diff;
	logic                 fits;
	logic [QUOT_W-1:0]    auc_clamped;
	logic                 load_out;

	always_comb begin
		scaled_in   = SCALE_W'(fin.total) + (SCALE_W'(fin.total) << 3)
			+ (SCALE_W'(fin.total) << 4);
		scaled_hi   = DEN_W'(scaled_q >> HI_SHIFT);
		trial       = {rem_q, low_q[QUOT_W-1]};
		diff        = trial - {1'b0, den_q};
		fits        = (trial >= {1'b0, den_q});
		auc_clamped = (quo_q > FULL_Q16) ? FULL_Q16 : quo_q;
		// A finished quotient moves out when the output is free or is being taken.
		load_out    = (state_q == ST_DONE) && (!out_valid_q || pop);
	end

	assign fin_ready = (state_q == ST_IDLE);
	assign result    = out_q;
	assign empty     = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			step_q      <= '0;
		end else begin
			if (load_out) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (fin_valid) state_q <= ST_PREP;
				end
				ST_PREP: begin
					if (den_q == '0 || info_q.neg == '0) begin
						state_q <= ST_DONE;
					end else if (scaled_hi >= den_q) begin
						// The quotient would not fit; it clamps to full scale anyway.
						state_q <= ST_DONE;
					end else begin
						step_q  <= STEP_W'(QUOT_W);
						state_q <= ST_ITER;
					end
				end
				ST_ITER: begin
					step_q <= step_q - 1'b1;
					if (step_q == STEP_W'(1)) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_out) begin
						out_q.auc_percent_q16 <= AUC_W'(auc_clamped);
						out_q.positives       <= COUNT_OUT_W'(info_q.pos);
						out_q.negatives       <= COUNT_OUT_W'(info_q.neg);
						out_q.overflowed      <= info_q.sat;
						state_q               <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (fin_valid) begin
					scaled_q <= scaled_in;
					den_q    <= DEN_W'(fin.info.div_a) * DEN_W'(fin.info.pos);
					info_q   <= fin.info;
				end
			end
			ST_PREP: begin
				if (den_q == '0 || info_q.neg == '0) begin
					quo_q <= '0;
				end else if (scaled_hi >= den_q) begin
					quo_q <= FULL_Q16;
				end else begin
					rem_q <= scaled_hi;
					low_q <= {scaled_q[HI_SHIFT-1:0], Q15_SHIFT'(0)};
					quo_q <= '0;
				end
			end
			ST_ITER: begin
				rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				quo_q <= {quo_q[QUOT_W-2:0], fits};
				low_q <= low_q << 1;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// File: bench/roc_auc_accumulator_tb.sv
// Self-checking testbench for roc_auc_accumulator: drives scored, labelled items through
// random idling on both queue sides and checks every area result against its own predictor.
// Depends on rocauc_pkg and the roc_auc_accumulator RTL.
`timescale 1ns / 1ps

module roc_auc_accumulator_tb;
	import rocauc_pkg::*;

	localparam int          SETTLE      = 48;
	localparam int          CYCLE_LIMIT = 4_000_000;
	localparam int          RANDOM_ITEMS = 1700;
	localparam logic [63:0] PERCENT_Q15 = 64'd3276800;

	typedef enum logic [1:0] {STEP_PAIR, STEP_WRITE, STEP_DRAIN} step_kind_t;

	typedef struct packed {
		step_kind_t               kind;
		in_item_t                 pair;
		logic [CFG_INDEX_W-1:0]   index;
		logic [LIMIT_W-1:0]       value;
		logic [4:0]               gap;
		logic [20:0]              copies;
	} step_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   push     = 1'b0;
	logic                   full;
	in_item_t               item     = '0;
	logic                   empty;
	logic                   pop      = 1'b0;
	result_t                result;
	logic                   wr_en    = 1'b0;
	logic [CFG_INDEX_W-1:0] wr_index = '0;
	logic [LIMIT_W-1:0]     wr_data  = '0;

	step_t   plan[$];
	result_t pending_auc[$];

	// Shadow of the registers and of the per-set tallies
	logic               mode_sh  = 1'b0;
	logic [LIMIT_W-1:0] limit_sh = NEG_LIMIT_RESET;
	logic [63:0]        tally_pos = '0, tally_neg = '0, brk_pos = '0, brk_neg = '0;
	logic [63:0]        area2 = '0;
	logic [SCORE_W-1:0] prev_score = '0;
	logic               prev_valid = 1'b0, tally_sat = 1'b0;

	int errors = 0, items_in = 0, results_checked = 0, writes_seen = 0, cycles = 0;
	int gap_left = 0, quiet = 0, stall_left = 0, calm_left = 0;
	bit calm_set = 1'b0;

	roc_auc_accumulator i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void clear_tallies();
		tally_pos  = '0;
		tally_neg  = '0;
		brk_pos    = '0;
		brk_neg    = '0;
		area2      = '0;
		prev_score = '0;
		prev_valid = 1'b0;
		tally_sat  = 1'b0;
	endfunction

	function automatic void close_tie_bin();
		area2   = area2 + (tally_neg - brk_neg) * (tally_pos + brk_pos);
		brk_neg = tally_neg;
		brk_pos = tally_pos;
	endfunction

	// Folds one item into the tallies; returns 1 with the area when the item ends a set.
	function automatic bit fold_pair(input in_item_t pair, output result_t res);
		logic         roc50;
		logic         open_bin;
		logic [63:0]  divisor;
		logic [127:0] quot;
		roc50    = mode_sh;
		open_bin = !roc50 || (tally_neg < 64'(limit_sh));
		res      = '0;
		if ((!prev_valid || pair.score != prev_score) && open_bin) begin
			close_tie_bin();
			prev_score = pair.score;
			prev_valid = 1'b1;
		end
		if (pair.is_positive) begin
			if (tally_pos < 64'(COUNT_MAX))
				tally_pos = tally_pos + 1;
			else
				tally_sat = 1'b1;
		end else if (open_bin) begin
			if (tally_neg < 64'(COUNT_MAX))
				tally_neg = tally_neg + 1;
			else
				tally_sat = 1'b1;
		end
		if (!pair.last)
			return 1'b0;
		close_tie_bin();
		divisor = (roc50 ? 64'(limit_sh) : tally_neg) * tally_pos;
		quot    = '0;
		if (tally_pos != 0 && tally_neg != 0 && divisor != 0) begin
			quot = ({64'd0, area2} * {64'd0, PERCENT_Q15}) / {64'd0, divisor};
			if (quot > 128'(FULL_Q16))
				quot = 128'(FULL_Q16);
		end
		res.auc_percent_q16 = quot[AUC_W-1:0];
		res.positives       = tally_pos[COUNT_OUT_W-1:0];
		res.negatives       = tally_neg[COUNT_OUT_W-1:0];
		res.overflowed      = tally_sat;
		clear_tallies();
		return 1'b1;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	// Sender: one item in flight, a drawn gap after each accepted item
	always @(posedge clk or negedge arst_n) begin
		logic                   push_n;
		in_item_t               item_n;
		logic                   wr_en_n;
		logic [CFG_INDEX_W-1:0] index_n;
		logic [LIMIT_W-1:0]     data_n;
		step_t                  head;
		if (!arst_n) begin
			push     <= 1'b0;
			item     <= '0;
			wr_en    <= 1'b0;
			wr_index <= '0;
			wr_data  <= '0;
			gap_left = 0;
			quiet    = 0;
		end else begin
			push_n  = push && full;
			item_n  = item;
			wr_en_n = 1'b0;
			index_n = wr_index;
			data_n  = wr_data;
			quiet   = (pending_auc.size() == 0 && !push) ? quiet + 1 : 0;
			if (!push_n && plan.size() != 0) begin
				head = plan[0];
				if (gap_left > 0) begin
					gap_left--;
				end else begin
					case (head.kind)
						STEP_PAIR: begin
							item_n   = head.pair;
							push_n   = 1'b1;
							gap_left = int'(head.gap);
							if (head.copies > 1) begin
								head.copies = head.copies - 1;
								plan[0]     = head;
							end else begin
								void'(plan.pop_front());
							end
						end
						STEP_WRITE: begin
							wr_en_n = 1'b1;
							index_n = head.index;
							data_n  = head.value;
							void'(plan.pop_front());
						end
						STEP_DRAIN: begin
							if (quiet >= SETTLE)
								void'(plan.pop_front());
						end
						default: void'(plan.pop_front());
					endcase
				end
			end
			push     <= push_n;
			item     <= item_n;
			wr_en    <= wr_en_n;
			wr_index <= index_n;
			wr_data  <= data_n;
		end
	end

	// Receiver: a drawn stall after each accepted result, with calm stretches now and then
	always @(posedge clk or negedge arst_n) begin
		logic pop_n;
		if (!arst_n) begin
			pop <= 1'b0;
			stall_left = 0;
			calm_left  = 0;
		end else begin
			pop_n = pop;
			if (pop && !empty) begin
				if (calm_left > 0) begin
					calm_left--;
					stall_left = 0;
				end else begin
					stall_left = $urandom_range(0, 19);
					if ($urandom_range(0, 15) == 0)
						calm_left = $urandom_range(8, 30);
				end
				pop_n = (stall_left == 0);
			end else if (!pop) begin
				if (stall_left > 0)
					stall_left--;
				pop_n = (stall_left == 0);
			end
			pop <= pop_n;
		end
	end

	// Monitor: shadows register writes, predicts on accepted items, checks accepted results
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			mode_sh  = 1'b0;
			limit_sh = NEG_LIMIT_RESET;
			clear_tallies();
		end else begin
			if (wr_en) begin
				writes_seen++;
				case (wr_index)
					CFG_MODE:      mode_sh  = wr_data[0];
					CFG_NEG_LIMIT: limit_sh = wr_data;
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (pending_auc.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d",
						$time, result.auc_percent_q16, result.positives, result.negatives,
						result.overflowed);
				end else begin
					want = pending_auc.pop_front();
					results_checked++;
					check_field("auc_percent_q16", 32'(want.auc_percent_q16),
						32'(result.auc_percent_q16));
					check_field("positives", 32'(want.positives), 32'(result.positives));
					check_field("negatives", 32'(want.negatives), 32'(result.negatives));
					check_field("overflowed", 32'(want.overflowed), 32'(result.overflowed));
				end
			end
			if (push && !full) begin
				items_in++;
				if (fold_pair(item, want))
					pending_auc = {pending_auc, want};
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_auc.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic [4:0] draw_gap();
		return calm_set ? 5'd0 : 5'($urandom_range(0, 19));
	endfunction

	task automatic add_pair(input logic [SCORE_W-1:0] score, input logic positive,
			input logic last);
		step_t st;
		st                  = '0;
		st.kind             = STEP_PAIR;
		st.pair.score       = score;
		st.pair.is_positive = positive;
		st.pair.last        = last;
		st.gap              = draw_gap();
		st.copies           = 21'd1;
		plan = {plan, st};
	endtask

	// Waits for the block to go idle, then writes both registers
	task automatic set_config(input logic mode, input logic [LIMIT_W-1:0] limit);
		step_t st;
		st       = '0;
		st.kind  = STEP_DRAIN;
		plan = {plan, st};
		st.kind  = STEP_WRITE;
		st.index = CFG_MODE;
		st.value = LIMIT_W'(mode);
		plan = {plan, st};
		st.index = CFG_NEG_LIMIT;
		st.value = limit;
		plan = {plan, st};
	endtask

	// A set of falling scores with ties, where a large step can wrap; a few sets jump about at random.
	task automatic add_random_set(input int len);
		logic [SCORE_W-1:0] s;
		int                 bias;
		bit                 jumbled;
		s        = $urandom;
		bias     = $urandom_range(0, 100);
		jumbled  = ($urandom_range(0, 19) == 0);
		calm_set = ($urandom_range(0, 4) == 0);
		for (int i = 0; i < len; i++) begin
			if (jumbled)
				s = $urandom;
			else if (i != 0 && $urandom_range(0, 2) != 0)
				s = s - (($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 50));
			add_pair(s, $urandom_range(0, 99) < bias, i == len - 1);
		end
		calm_set = 1'b0;
	endtask

	initial begin
		int    random_items;
		int    next_switch;
		int    len;
		int    pick;
		logic [LIMIT_W-1:0] lim;

		// Reset values: single-label sets give zero, then full ROC area
		add_pair(32'h7FFF_FFFF, 1'b1, 1'b1);
		add_pair(32'h8000_0000, 1'b0, 1'b1);
		add_pair(32'h7FFF_FFFF, 1'b1, 1'b0);
		add_pair(32'h8000_0000, 1'b0, 1'b1);
		// A first score of zero must still open a bin; all ties give half the area, a negative above a positive none
		add_pair(32'h0, 1'b1, 1'b0);
		add_pair(32'h0, 1'b0, 1'b0);
		add_pair(32'h0, 1'b1, 1'b0);
		add_pair(32'h0, 1'b0, 1'b1);
		add_pair(32'hFFFF_FFFF, 1'b0, 1'b0);
		add_pair(32'hFFFF_FFFE, 1'b1, 1'b1);
		// ROC50: negatives capped at the limit
		set_config(1'b1, 10'd2);
		add_pair(32'd9, 1'b0, 1'b0);
		add_pair(32'd8, 1'b1, 1'b0);
		add_pair(32'd7, 1'b0, 1'b0);
		add_pair(32'd6, 1'b0, 1'b0);
		add_pair(32'd5, 1'b1, 1'b1);
		// Fewer negatives than the limit still divides by the limit
		set_config(1'b1, 10'd5);
		add_pair(32'd3, 1'b1, 1'b0);
		add_pair(32'd2, 1'b0, 1'b0);
		add_pair(32'd1, 1'b1, 1'b1);
		// A zero limit counts no negatives at all; then a set with a tie under a limit of 1023
		set_config(1'b1, 10'd0);
		add_pair(32'd4, 1'b1, 1'b0);
		add_pair(32'd3, 1'b0, 1'b1);
		set_config(1'b1, 10'd1023);
		add_pair(32'd2, 1'b0, 1'b0);
		add_pair(32'd2, 1'b1, 1'b0);
		add_pair(32'd1, 1'b1, 1'b1);

		random_items = 0;
		next_switch  = 0;
		while (random_items < RANDOM_ITEMS) begin
			if (random_items >= next_switch) begin
				pick = $urandom_range(0, 4);
				case (pick)
					0:       lim = 10'd1;
					1:       lim = 10'd1023;
					2:       lim = 10'($urandom_range(1, 30));
					default: lim = 10'($urandom_range(1, 1023));
				endcase
				set_config(1'($urandom_range(0, 1)), lim);
				next_switch = random_items + $urandom_range(120, 250);
			end
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 15);
			add_random_set(len);
			random_items += len;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		wait (plan.size() == 0);
		@(posedge clk);
		while (push || pending_auc.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Run covered %0d items in %0d checked area results, %0d register writes,",
			items_in, results_checked, writes_seen);
		$display("both area modes, limits from 0 to 1023, ties, jumbled and degenerate sets.");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: sim.f
src/rocauc_pkg.sv
src/rocauc_front.sv
src/rocauc_queue.sv
src/rocauc_mac.sv
src/rocauc_div.sv
src/roc_auc_accumulator.sv
bench/roc_auc_accumulator_tb.sv
